// ----- sv/click_code_lock_controller_macros.svh -----
// Assertion macros shared by the code lock RTL.
`ifndef CLICK_CODE_LOCK_CONTROLLER_MACROS_SVH
`define CLICK_CODE_LOCK_CONTROLLER_MACROS_SVH

// Same-cycle implication, sampled on clk and idle during reset.
`define CLCL_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and idle during reset.
`define CLCL_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/clcl_pkg.sv -----
// Types and constants for the click code lock controller.
`default_nettype none
package clcl_pkg;

	localparam int unsigned TIMER_W = 24;
	localparam int unsigned SYM_W   = 4;
	localparam int unsigned CMD_W   = 2;
	localparam int unsigned LEN_W   = 4;
	localparam int unsigned CFG_IW  = 2;
	localparam int unsigned CFG_DW  = 24;

	localparam logic [TIMER_W-1:0] ATTEMPT_RESET = 24'd60000;
	localparam logic [TIMER_W-1:0] IDLE_RESET    = 24'd2500;
	localparam logic [LEN_W-1:0]   MIN_LEN_RESET = 4'd3;

	localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_CLICK = 2'd1;
	localparam logic [CMD_W-1:0] CMD_SETUP = 2'd2;

	localparam logic [CFG_IW-1:0] REG_ATTEMPT = 2'd0;
	localparam logic [CFG_IW-1:0] REG_IDLE    = 2'd1;
	localparam logic [CFG_IW-1:0] REG_MIN_LEN = 2'd2;

	localparam int unsigned RES_Q_DEPTH = 8;
	localparam int unsigned RES_Q_CNTW  = $clog2(RES_Q_DEPTH + 1);

	typedef enum logic [2:0] {
		MODE_VERIFY  = 3'b001,
		MODE_CONFIRM = 3'b010,
		MODE_SETNEW  = 3'b100
	} mode_t;

	typedef enum logic [3:0] {
		ST_TYPING    = 4'd0,
		ST_GRANTED   = 4'd1,
		ST_DENIED    = 4'd2,
		ST_NO_CODE   = 4'd3,
		ST_TOO_SHORT = 4'd4,
		ST_ASK_OLD   = 4'd5,
		ST_ENTER_NEW = 4'd6,
		ST_OLD_WRONG = 4'd7,
		ST_SAVED     = 4'd8,
		ST_TIMEOUT   = 4'd9
	} status_t;

	typedef struct packed {
		status_t          status;
		logic [LEN_W-1:0] entered_len;
		logic             unlock;
		logic             last;
	} res_t;

	typedef struct packed {
		logic [1:0] n;
		res_t       r0;
		res_t       r1;
	} push_t;

endpackage
`default_nettype wire

// ----- sv/clcl_item_if.sv -----
// Input channel of the code lock: command and click symbol.
`default_nettype none
interface clcl_item_if;
	logic       valid;
	logic       ready;
	logic [1:0] cmd;
	logic [3:0] click_symbol;

	modport source (output valid, cmd, click_symbol, input ready);
	modport sink (input valid, cmd, click_symbol, output ready);
endinterface
`default_nettype wire

// ----- sv/clcl_result_if.sv -----
// Result channel of the code lock: status, entered length, unlock and last mark.
`default_nettype none
interface clcl_result_if;
	logic       valid;
	logic       ready;
	logic [3:0] status;
	logic [3:0] entered_len;
	logic       unlock;
	logic       last;

	modport source (output valid, status, entered_len, unlock, last, input ready);
	modport sink (input valid, status, entered_len, unlock, last, output ready);
endinterface
`default_nettype wire

// ----- sv/clcl_core.sv -----
// Input register, lock state and per-item result generation.
`default_nettype none
`include "click_code_lock_controller_macros.svh"
module clcl_core #(
	parameter int unsigned MAX_CODE_LEN = 14
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          accept,
	input  wire logic [clcl_pkg::CMD_W-1:0]    cmd,
	input  wire logic [clcl_pkg::SYM_W-1:0]    click_symbol,
	input  wire logic                          cfg_wr_en,
	input  wire logic [clcl_pkg::CFG_IW-1:0]   cfg_index,
	input  wire logic [clcl_pkg::CFG_DW-1:0]   cfg_wdata,
	output clcl_pkg::push_t                    push
);
	localparam int unsigned CW = $clog2(MAX_CODE_LEN + 1);
	localparam int unsigned IW = $clog2(MAX_CODE_LEN);
	localparam int unsigned MW = (CW > clcl_pkg::LEN_W) ? CW : clcl_pkg::LEN_W;
	localparam int unsigned TW = clcl_pkg::TIMER_W;

	logic                           valid_s1;
	logic [clcl_pkg::CMD_W-1:0]     cmd_s1;
	logic [clcl_pkg::SYM_W-1:0]     sym_s1;

	logic [TW-1:0]                  att_cfg_q, idle_cfg_q;
	logic [clcl_pkg::LEN_W-1:0]     min_len_q;

	clcl_pkg::mode_t                mode_q, mode_n;
	logic                           code_set_q, code_set_n;
	logic [CW-1:0]                  cnt_q, cnt_n, slen_q;
	logic [TW-1:0]                  at_q, at_n, id_q, id_n;
	logic [clcl_pkg::SYM_W-1:0]     ent_q [MAX_CODE_LEN];
	logic [clcl_pkg::SYM_W-1:0]     ent_w [MAX_CODE_LEN];
	logic [clcl_pkg::SYM_W-1:0]     stored_q [MAX_CODE_LEN];

	logic [CW-1:0]                  cnt_w, sub_cnt;
	logic [TW-1:0]                  at_inc, id_inc;
	logic                           mismatch, match;
	logic                           ent_we, store_we, do_sub, sub_slot, clear;
	clcl_pkg::status_t              sub_status;
	clcl_pkg::mode_t                sub_mode;
	logic                           sub_unlock, sub_store;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd;
			sym_s1 <= click_symbol;
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			att_cfg_q  <= clcl_pkg::ATTEMPT_RESET;
			idle_cfg_q <= clcl_pkg::IDLE_RESET;
			min_len_q  <= clcl_pkg::MIN_LEN_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				clcl_pkg::REG_ATTEMPT: att_cfg_q  <= cfg_wdata[TW-1:0];
				clcl_pkg::REG_IDLE:    idle_cfg_q <= cfg_wdata[TW-1:0];
				clcl_pkg::REG_MIN_LEN: min_len_q  <= cfg_wdata[clcl_pkg::LEN_W-1:0];
				default: ;
			endcase
		end
	end

	assign cnt_w   = CW'(cnt_q + 1'b1);
	assign sub_cnt = (cmd_s1 == clcl_pkg::CMD_CLICK) ? cnt_w : cnt_q;
	assign at_inc  = (at_q == '1) ? at_q : TW'(at_q + 1'b1);
	assign id_inc  = (id_q == '1) ? id_q : TW'(id_q + 1'b1);

	// The entry with the current symbol written at the next free place.
	always_comb begin
		ent_w = ent_q;
		ent_w[cnt_q[IW-1:0]] = sym_s1;
	end

	always_comb begin
		mismatch = 1'b0;
		for (int i = 0; i < MAX_CODE_LEN; i++) begin
			if ((CW'(i) < slen_q) && (ent_w[i] != stored_q[i])) begin
				mismatch = 1'b1;
			end
		end
		match = (sub_cnt == slen_q) && !mismatch;
	end

	// Outcome of submitting the entry.
	always_comb begin
		sub_status = clcl_pkg::ST_DENIED;
		sub_mode   = clcl_pkg::MODE_VERIFY;
		sub_unlock = 1'b0;
		sub_store  = 1'b0;
		if (MW'(sub_cnt) < MW'(min_len_q)) begin
			sub_status = clcl_pkg::ST_TOO_SHORT;
		end else begin
			case (mode_q)
				clcl_pkg::MODE_CONFIRM: begin
					if (match) begin
						sub_status = clcl_pkg::ST_ENTER_NEW;
						sub_mode   = clcl_pkg::MODE_SETNEW;
					end else begin
						sub_status = clcl_pkg::ST_OLD_WRONG;
					end
				end
				clcl_pkg::MODE_SETNEW: begin
					sub_status = clcl_pkg::ST_SAVED;
					sub_store  = 1'b1;
				end
				default: begin
					if (match) begin
						sub_status = clcl_pkg::ST_GRANTED;
						sub_unlock = 1'b1;
					end
				end
			endcase
		end
	end

	always_comb begin
		mode_n     = mode_q;
		code_set_n = code_set_q;
		cnt_n      = cnt_q;
		at_n       = at_q;
		id_n       = id_q;
		ent_we     = 1'b0;
		store_we   = 1'b0;
		do_sub     = 1'b0;
		sub_slot   = 1'b0;
		clear      = 1'b0;
		push       = '0;
		if (valid_s1) begin
			case (cmd_s1)
				clcl_pkg::CMD_TICK: begin
					if (cnt_q != '0) begin
						at_n = at_inc;
						id_n = id_inc;
						if (at_inc > att_cfg_q) begin
							clear            = 1'b1;
							mode_n           = clcl_pkg::MODE_VERIFY;
							push.n           = 2'd1;
							push.r0.status   = clcl_pkg::ST_TIMEOUT;
						end else if (id_inc > idle_cfg_q) begin
							do_sub = 1'b1;
						end
					end
				end
				clcl_pkg::CMD_CLICK: begin
					if (mode_q == clcl_pkg::MODE_VERIFY && !code_set_q) begin
						push.n         = 2'd1;
						push.r0.status = clcl_pkg::ST_NO_CODE;
					end else begin
						if (cnt_q == '0) begin
							at_n = '0;
						end
						id_n                = '0;
						ent_we              = 1'b1;
						cnt_n               = cnt_w;
						push.n              = 2'd1;
						push.r0.status      = clcl_pkg::ST_TYPING;
						push.r0.entered_len = clcl_pkg::LEN_W'(cnt_w);
						if (cnt_w == CW'(MAX_CODE_LEN)) begin
							do_sub   = 1'b1;
							sub_slot = 1'b1;
						end
					end
				end
				clcl_pkg::CMD_SETUP: begin
					if (mode_q == clcl_pkg::MODE_VERIFY && cnt_q == '0) begin
						clear  = 1'b1;
						push.n = 2'd1;
						if (code_set_q) begin
							mode_n         = clcl_pkg::MODE_CONFIRM;
							push.r0.status = clcl_pkg::ST_ASK_OLD;
						end else begin
							mode_n         = clcl_pkg::MODE_SETNEW;
							push.r0.status = clcl_pkg::ST_ENTER_NEW;
						end
					end
				end
				default: ;
			endcase
		end
		if (do_sub) begin
			clear  = 1'b1;
			mode_n = sub_mode;
			if (sub_store) begin
				store_we   = 1'b1;
				code_set_n = 1'b1;
			end
			if (sub_slot) begin
				push.n           = 2'd2;
				push.r1.status   = sub_status;
				push.r1.unlock   = sub_unlock;
			end else begin
				push.n           = 2'd1;
				push.r0.status   = sub_status;
				push.r0.unlock   = sub_unlock;
			end
		end
		if (clear) begin
			cnt_n = '0;
			at_n  = '0;
			id_n  = '0;
		end
		push.r0.last = (push.n == 2'd1);
		push.r1.last = (push.n == 2'd2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= clcl_pkg::MODE_VERIFY;
			code_set_q <= 1'b0;
			cnt_q      <= '0;
			slen_q     <= '0;
			at_q       <= '0;
			id_q       <= '0;
		end else begin
			mode_q     <= mode_n;
			code_set_q <= code_set_n;
			cnt_q      <= cnt_n;
			at_q       <= at_n;
			id_q       <= id_n;
			if (store_we) begin
				slen_q <= sub_cnt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ent_we) begin
			ent_q <= ent_w;
		end
		if (store_we) begin
			stored_q <= ent_w;
		end
	end

	`CLCL_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q < CW'(MAX_CODE_LEN), "entry count reached the full length")
	`CLCL_ASSERT_NEXT(a_code_sticky, code_set_q, code_set_q, "stored code was lost")
	`CLCL_ASSERT_NOW(a_pair_on_click, push.n == 2'd2, valid_s1 && cmd_s1 == clcl_pkg::CMD_CLICK, "two results without a click")
	`CLCL_ASSERT_NOW(a_unlock_granted, push.r0.unlock, push.r0.status == clcl_pkg::ST_GRANTED, "unlock without granted status")

endmodule
`default_nettype wire

// ----- sv/clcl_res_fifo.sv -----
// Result queue taking up to two results per cycle and giving one.
`default_nettype none
`include "click_code_lock_controller_macros.svh"
module clcl_res_fifo (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire clcl_pkg::push_t                  push,
	input  wire logic                             pop,
	output logic                                  valid,
	output clcl_pkg::res_t                        head,
	output logic [clcl_pkg::RES_Q_CNTW-1:0]       count
);
	localparam int unsigned DEPTH = clcl_pkg::RES_Q_DEPTH;
	localparam int unsigned IW    = $clog2(DEPTH);
	localparam int unsigned NW    = clcl_pkg::RES_Q_CNTW;

	clcl_pkg::res_t  mem_q [DEPTH];
	logic [IW-1:0]   wr_q, rd_q;
	logic [NW-1:0]   count_q;
	logic            pop_do;

	assign valid  = (count_q != '0);
	assign head   = mem_q[rd_q];
	assign count  = count_q;
	assign pop_do = pop && valid;

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			mem_q[wr_q] <= push.r0;
		end
		if (push.n == 2'd2) begin
			mem_q[IW'(wr_q + 1'b1)] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= IW'(wr_q + IW'(push.n));
			rd_q    <= IW'(rd_q + IW'(pop_do));
			count_q <= NW'(count_q + NW'(push.n) - NW'(pop_do));
		end
	end

	`CLCL_ASSERT_NOW(a_no_overflow, push.n != 2'd0, ({1'b0, count_q} + (NW + 1)'(push.n)) <= (NW + 1)'(DEPTH), "result queue overflow")
	`CLCL_ASSERT_NOW(a_ptr_gap, count_q != NW'(DEPTH), IW'(wr_q - rd_q) == count_q[IW-1:0], "queue pointers disagree with count")

endmodule
`default_nettype wire

// ----- sv/click_code_lock_controller.sv -----
// An accepted item is held in the input register, and its results are written to the result queue,
// from which the first is offered on the result port.
// One item per cycle while the result queue has room; the result port gives one result per cycle,
// so an item that ends an entry with a full code gives two results.
// Input is held off while the eight-entry result queue could not take two more results.
// Reset clears mode, code-set flag, entry count, timers and registers to their defaults.
`default_nettype none
module click_code_lock_controller #(
	parameter int unsigned MAX_CODE_LEN = 14
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_wr_en,
	input  wire logic [clcl_pkg::CFG_IW-1:0]   cfg_index,
	input  wire logic [clcl_pkg::CFG_DW-1:0]   cfg_wdata,
	clcl_item_if.sink                          item,
	clcl_result_if.source                      result
);
	localparam int unsigned NW = clcl_pkg::RES_Q_CNTW + 1;

	clcl_pkg::push_t                   push;
	clcl_pkg::res_t                    q_head;
	logic                              q_valid;
	logic [clcl_pkg::RES_Q_CNTW-1:0]   q_count;
	logic                              accept;

	assign item.ready = (NW'(q_count) + NW'(push.n)) <= NW'(clcl_pkg::RES_Q_DEPTH - 2);
	assign accept     = item.valid && item.ready;

	clcl_core #(
		.MAX_CODE_LEN (MAX_CODE_LEN)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.cmd          (item.cmd),
		.click_symbol (item.click_symbol),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.push         (push)
	);

	clcl_res_fifo u_res_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (result.ready),
		.valid  (q_valid),
		.head   (q_head),
		.count  (q_count)
	);

	assign result.valid       = q_valid;
	assign result.status      = q_head.status;
	assign result.entered_len = q_head.entered_len;
	assign result.unlock      = q_head.unlock;
	assign result.last        = q_head.last;

endmodule
`default_nettype wire
